// ===== sv/nlcc_pkg.sv =====
// Shared types, character codes and helper functions for the NMEA line checksum checker.
// No dependencies.
package nlcc_pkg;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_X_LO  = 8'h78;
  localparam logic [7:0] CHAR_X_UP  = 8'h58;

  localparam logic [7:0] DELIM_RESET = 8'h2A;  // '*'

  typedef enum logic [1:0] {
    RES_MATCH    = 2'd0,
    RES_MISMATCH = 2'd1,
    RES_NO_DELIM = 2'd2
  } result_code_t;

  // Hex field parse phase.
  typedef enum logic [6:0] {
    PH_NONE   = 7'b0000001,
    PH_BLANKS = 7'b0000010,
    PH_SIGNED = 7'b0000100,
    PH_ZERO   = 7'b0001000,
    PH_XPEND  = 7'b0010000,
    PH_DIGITS = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] running_xor;
    logic [7:0] hex_magnitude;
    logic       hex_overflow;
    logic       hex_negative;
    logic       first_byte_seen;
    logic       text_terminated;
    logic       sum_closed;
  } line_state_t;

  localparam line_state_t LINE_CLEAR = '{
    phase:           PH_NONE,
    running_xor:     8'h00,
    hex_magnitude:   8'h00,
    hex_overflow:    1'b0,
    hex_negative:    1'b0,
    first_byte_seen: 1'b0,
    text_terminated: 1'b0,
    sum_closed:      1'b0
  };

  typedef struct packed {
    result_code_t result_code;
    logic [7:0]   computed_sum;
    logic [7:0]   stated_value;
    logic         ended_by_eof;
  } line_result_t;

  // {valid, digit value}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_VT) || (b == CHAR_FF);
  endfunction

endpackage

// ===== sv/nlcc_if.sv =====
// Valid/ready channel interfaces for the text input and the line result output.
// Depends on nlcc_pkg for the result code type.
interface nlcc_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, data_byte, end_of_file, input ready);
  modport sink   (input valid, data_byte, end_of_file, output ready);
endinterface

interface nlcc_result_if;
  logic                  valid;
  logic                  ready;
  nlcc_pkg::result_code_t result_code;
  logic [7:0]            computed_sum;
  logic [7:0]            stated_value;
  logic                  ended_by_eof;

  modport source (output valid, result_code, computed_sum, stated_value, ended_by_eof,
                  input ready);
  modport sink   (input valid, result_code, computed_sum, stated_value, ended_by_eof,
                  output ready);
endinterface

// ===== sv/nlcc_step.sv =====
// Per-byte next-state and line-result logic of the checksum checker (combinational).
// Depends on nlcc_pkg.
module nlcc_step (
  input  nlcc_pkg::line_state_t  cur,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_file,
  input  logic [7:0]             delimiter,
  output nlcc_pkg::line_state_t  next,
  output logic                   res_valid,
  output nlcc_pkg::line_result_t res
);

  logic [4:0] hd;
  logic       digit_ok;
  logic [3:0] digit;
  logic       is_delim;
  logic       ok;

  assign hd       = nlcc_pkg::hex_digit(data_byte);
  assign digit_ok = hd[4];
  assign digit    = hd[3:0];
  assign is_delim = (data_byte == delimiter);

  always_comb begin
    next      = cur;
    res_valid = 1'b0;
    res       = '{result_code: nlcc_pkg::RES_NO_DELIM, computed_sum: cur.running_xor,
                  stated_value: cur.hex_magnitude, ended_by_eof: end_of_file};
    ok        = !cur.hex_overflow && (cur.hex_magnitude == cur.running_xor) &&
                (!cur.hex_negative || (cur.hex_magnitude == 8'h00));

    if (end_of_file || data_byte == nlcc_pkg::CHAR_LF) begin
      res_valid = 1'b1;
      if (delimiter == 8'h00) begin
        res.stated_value = 8'h00;
        if (!cur.first_byte_seen) res.result_code = nlcc_pkg::RES_NO_DELIM;
        else if (cur.running_xor == 8'h00) res.result_code = nlcc_pkg::RES_MATCH;
        else res.result_code = nlcc_pkg::RES_MISMATCH;
      end else if (!cur.sum_closed) begin
        res.result_code = nlcc_pkg::RES_NO_DELIM;
      end else begin
        res.result_code = ok ? nlcc_pkg::RES_MATCH : nlcc_pkg::RES_MISMATCH;
      end
      next = nlcc_pkg::LINE_CLEAR;
    end else if (data_byte == nlcc_pkg::CHAR_CR || cur.text_terminated) begin
      next = cur;
    end else if (data_byte == nlcc_pkg::CHAR_NUL) begin
      next.text_terminated = 1'b1;
    end else begin
      // checksummed span: index 1 up to the first delimiter
      if (cur.first_byte_seen && !cur.sum_closed) begin
        if (is_delim) next.sum_closed = 1'b1;
        else next.running_xor = cur.running_xor ^ data_byte;
      end
      next.first_byte_seen = 1'b1;

      unique case (cur.phase)
        nlcc_pkg::PH_NONE: begin
          if (is_delim) next.phase = nlcc_pkg::PH_BLANKS;
        end
        nlcc_pkg::PH_BLANKS, nlcc_pkg::PH_SIGNED, nlcc_pkg::PH_ZERO,
        nlcc_pkg::PH_XPEND, nlcc_pkg::PH_DIGITS: begin
          priority if (cur.phase == nlcc_pkg::PH_BLANKS &&
                       nlcc_pkg::is_blank(data_byte)) begin
            next.phase = cur.phase;
          end else if (cur.phase == nlcc_pkg::PH_BLANKS &&
                       (data_byte == nlcc_pkg::CHAR_PLUS ||
                        data_byte == nlcc_pkg::CHAR_MINUS)) begin
            next.hex_negative = (data_byte == nlcc_pkg::CHAR_MINUS);
            next.phase        = nlcc_pkg::PH_SIGNED;
          end else if ((cur.phase == nlcc_pkg::PH_BLANKS ||
                        cur.phase == nlcc_pkg::PH_SIGNED) &&
                       data_byte == nlcc_pkg::CHAR_ZERO) begin
            next.phase = nlcc_pkg::PH_ZERO;
          end else if (cur.phase == nlcc_pkg::PH_ZERO &&
                       (data_byte == nlcc_pkg::CHAR_X_LO ||
                        data_byte == nlcc_pkg::CHAR_X_UP)) begin
            next.phase = nlcc_pkg::PH_XPEND;
          end else if (digit_ok) begin
            next.phase = nlcc_pkg::PH_DIGITS;
            if (!cur.hex_overflow) begin
              // mag*16 + d exceeds 255 exactly when the top nibble is nonzero
              if (cur.hex_magnitude[7:4] != 4'h0) begin
                next.hex_overflow  = 1'b1;
                next.hex_magnitude = 8'hFF;
              end else begin
                next.hex_magnitude = {cur.hex_magnitude[3:0], digit};
              end
            end
          end else begin
            next.phase = nlcc_pkg::PH_DONE;
          end
        end
        nlcc_pkg::PH_DONE: begin
          next.phase = nlcc_pkg::PH_DONE;
        end
        default: begin
          next.phase = nlcc_pkg::PH_DONE;
        end
      endcase
    end
  end

endmodule

// ===== sv/nmea_line_checksum_checker.sv =====
// NMEA line checksum checker: XORs each line's body and compares it with the hex field.
// A line's result is registered when its line feed or end-of-file transaction is accepted.
// Throughput: one text transaction per cycle; a two-entry output buffer (output register plus
// skid register) lets input continue while a result waits, ready drops only when both are full.
// Reset (rst, synchronous, active high): line state cleared, delimiter back to '*', buffer empty.
// Depends on nlcc_pkg, nlcc_if.sv (channel interfaces) and nlcc_step.
module nmea_line_checksum_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          delimiter_we,
  input  logic [7:0]    delimiter_data,
  nlcc_text_if.sink     text,
  nlcc_result_if.source result
);

  // Configuration: delimiter byte; user must write it only while idle; block does not check.
  logic [7:0] delimiter;

  // Running per-line state.
  nlcc_pkg::line_state_t line_state;
  nlcc_pkg::line_state_t line_state_next;

  logic                   res_valid;
  nlcc_pkg::line_result_t res;

  // Output register and skid register.
  logic                   out_valid;
  nlcc_pkg::line_result_t out_data;
  logic                   skid_valid;
  nlcc_pkg::line_result_t skid_data;

  logic accept;
  logic push;
  logic pop;

  // Accept whenever the skid slot is free: a new result always has a place to go.
  assign text.ready = !skid_valid;
  assign accept     = text.valid && text.ready;
  assign push       = accept && res_valid;
  assign pop        = out_valid && result.ready;

  nlcc_step u_step (
    .cur         (line_state),
    .data_byte   (text.data_byte),
    .end_of_file (text.end_of_file),
    .delimiter   (delimiter),
    .next        (line_state_next),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= nlcc_pkg::DELIM_RESET;
    end else if (delimiter_we) begin
      delimiter <= delimiter_data;
    end
  end

  // Line state advances on every accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_state <= nlcc_pkg::LINE_CLEAR;
    end else if (accept) begin
      line_state <= line_state_next;
    end
  end

  // Output buffer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      // Output slot frees up: refill from skid first, else from the new result.
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Output buffer payload (no reset needed).
  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= res;
      end
    end else if (push) begin
      skid_data <= res;
    end
  end

  assign result.valid        = out_valid;
  assign result.result_code  = out_data.result_code;
  assign result.computed_sum = out_data.computed_sum;
  assign result.stated_value = out_data.stated_value;
  assign result.ended_by_eof = out_data.ended_by_eof;

endmodule
